// ===== src/pending_request_tracker_timeout_assert.svh =====
// Assertion macros for the pending request tracker
`ifndef PENDING_REQUEST_TRACKER_TIMEOUT_ASSERT_SVH
`define PENDING_REQUEST_TRACKER_TIMEOUT_ASSERT_SVH

// a holds in the same cycle implies c
`define PRT_ASSERT_NOW(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// a implies c in the next cycle
`define PRT_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== src/prt_pkg.sv =====
`timescale 1ns / 1ps
package prt_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int CORR_W = 8;
  localparam int AGE_W = 16;
  localparam int TIME_W = 32;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd1000;

  typedef enum logic [2:0] {
    OP_REQUEST = 3'd0, OP_ACK = 3'd1, OP_MATCH = 3'd2, OP_ERASE = 3'd3,
    OP_EXPIRED = 3'd4, OP_CHECK = 3'd5, OP_SWEEP = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0, ACT_SEND_REQ = 3'd1, ACT_SEND_CONF = 3'd2,
    ACT_FALLBACK = 3'd3, ACT_DROP = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0, ST_PENDING = 2'd1, ST_REJECTED = 2'd2
  } req_status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ADV, S_EXEC, S_SWEEP, S_WAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic adv;
    logic emit;
    logic cnt_clr;
    logic cnt_inc;
  } prt_cmd_t;

  typedef struct packed {
    logic is_sweep;
    logic hit;
    logic pending;
    logic out_take;
    logic out_last;
  } prt_stat_t;

  function automatic action_t check_action(logic acked, logic [AGE_W-1:0] age,
                                           logic [AGE_W-1:0] tmo, logic fo,
                                           logic rdy);
    action_t a;
    a = ACT_NONE;
    if (acked) begin
      if (age > tmo) a = ACT_DROP;
      else if (rdy) a = ACT_SEND_CONF;
    end else if (fo || age > tmo) begin
      a = ACT_FALLBACK;
    end
    return a;
  endfunction
endpackage

// ===== src/prt_ctrl.sv =====
`timescale 1ns / 1ps
module prt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  prt_pkg::prt_stat_t stat,
  output prt_pkg::prt_cmd_t  cmd
);
  import prt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        cmd.adv = 1'b1;
        if (stat.is_sweep) begin
          cmd.cnt_clr = 1'b1;
          state_nxt = S_SWEEP;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.emit = 1'b1;
        state_nxt = S_WAIT;
      end
      S_SWEEP: begin
        // emit on an acting slot, or a status word when nothing acts at all
        if (stat.hit || !stat.pending) begin
          cmd.emit = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_WAIT: begin
        if (stat.out_take) state_nxt = stat.out_last ? S_IDLE : S_SWEEP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== src/prt_datapath.sv =====
`timescale 1ns / 1ps
module prt_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [2:0]                         in_tuser,
  input  logic [prt_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               cfg_wr_en,
  input  logic [prt_pkg::AGE_W-1:0]          cfg_wr_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [prt_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [2:0]                         out_tuser,
  output logic                               out_tlast,
  input  prt_pkg::prt_cmd_t                  cmd,
  output prt_pkg::prt_stat_t                 stat
);
  import prt_pkg::*;

  logic [AGE_W-1:0]  age_r [SLOTS];
  logic [CORR_W-1:0] corr_r [SLOTS];
  logic [SLOTS-1:0]  act_r, ack_r;
  logic [CORR_W-1:0] id_r;
  logic [TIME_W-1:0] last_time_r;
  logic [AGE_W-1:0]  timeout_r;

  logic [2:0]        op_r;
  logic [SLOT_W-1:0] idx_r, cnt_r;
  logic [1:0]        type_r;
  logic [CORR_W-1:0] query_r;
  logic [TIME_W-1:0] now_r;
  logic              fo_r, rdy_r;

  logic              out_valid_r, out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [2:0]        out_user_r;

  logic [SLOT_W-1:0] a;
  logic              sup, found, adv_need, any_now;
  logic [CORR_W-1:0] cur, id_nxt;
  logic [TIME_W-1:0] dt;
  logic [AGE_W-1:0]  el;
  logic [AGE_W:0]    sum [SLOTS];
  logic [SLOTS-1:0]  acts;
  logic              more, pend;
  action_t           chk, r_act;
  req_status_t       r_status;
  logic [CORR_W-1:0] r_corr;
  logic              r_ans, r_last, do_free, do_fill, do_ack, id_bump;
  logic [SLOT_W-1:0] r_slot;
  logic [SLOTS-1:0]  act_after;

  always_comb begin
    a = (op_r == OP_SWEEP) ? cnt_r : idx_r;
    sup = (type_r == 2'd0) || (type_r == 2'd1);
    found = sup && act_r[a];
    cur = corr_r[a];
    id_nxt = id_r + 8'd1;
    if (id_nxt == '0) id_nxt = 8'd1;
    any_now = |act_r;
    dt = now_r - last_time_r;
    el = (dt > TIME_W'(AGE_MAX)) ? AGE_MAX : dt[AGE_W-1:0];
    for (int s = 0; s < SLOTS; s++) begin
      sum[s] = {1'b0, age_r[s]} + {1'b0, el};
      acts[s] = act_r[s] && (check_action(ack_r[s], age_r[s], timeout_r, fo_r, rdy_r)
                             != ACT_NONE);
    end
    more = 1'b0;
    pend = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (acts[s] && SLOT_W'(s) > cnt_r) more = 1'b1;
      if (acts[s] && SLOT_W'(s) >= cnt_r) pend = 1'b1;
    end
    case (op_r)
      OP_REQUEST: adv_need = sup && !found;
      OP_EXPIRED, OP_CHECK: adv_need = found;
      OP_SWEEP: adv_need = 1'b1;
      default: adv_need = 1'b0;
    endcase
    chk = check_action(ack_r[a], age_r[a], timeout_r, fo_r, rdy_r);

    r_act = ACT_NONE;
    r_status = ST_ACCEPTED;
    r_corr = cur;
    r_ans = 1'b0;
    r_last = 1'b1;
    r_slot = idx_r;
    do_free = 1'b0;
    do_fill = 1'b0;
    do_ack = 1'b0;
    id_bump = 1'b0;
    case (op_r)
      OP_REQUEST: begin
        if (!sup) r_status = ST_REJECTED;
        else if (found) r_status = ST_PENDING;
        else begin
          id_bump = 1'b1;
          if (rdy_r) begin
            do_fill = 1'b1;
            r_act = ACT_SEND_REQ;
            r_corr = id_nxt;
          end else begin
            r_status = ST_REJECTED;
            r_corr = '0;
          end
        end
      end
      OP_ACK: begin
        if (found) begin
          do_ack = 1'b1;
          if (rdy_r) begin
            do_free = 1'b1;
            r_act = ACT_SEND_CONF;
          end
        end
      end
      OP_MATCH: r_ans = (query_r != '0) && found && (cur == query_r);
      OP_ERASE: begin
        if (found) begin
          do_free = 1'b1;
          r_corr = '0;
        end
      end
      OP_EXPIRED: begin
        if (!found) r_ans = 1'b1;
        else if (age_r[a] > timeout_r) begin
          do_free = 1'b1;
          r_ans = 1'b1;
          r_corr = '0;
        end
      end
      OP_CHECK: begin
        if (found) begin
          r_act = chk;
          r_ans = (chk == ACT_FALLBACK);
          do_free = (chk != ACT_NONE);
        end
      end
      OP_SWEEP: begin
        if (acts[a]) begin
          r_act = chk;
          r_ans = (chk == ACT_FALLBACK);
          do_free = 1'b1;
          r_slot = cnt_r;
          r_last = !more;
        end else begin
          r_slot = '0;
          r_corr = '0;
        end
      end
      default: ;
    endcase
    act_after = act_r;
    if (do_free) act_after[a] = 1'b0;
    if (do_fill) act_after[a] = 1'b1;

    stat.is_sweep = (op_r == OP_SWEEP);
    stat.hit = acts[a];
    stat.pending = pend;
    stat.out_take = out_valid_r && out_tready;
    stat.out_last = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        age_r[s] <= '0;
        corr_r[s] <= '0;
      end
      act_r <= '0;
      ack_r <= '0;
      id_r <= '0;
      last_time_r <= '0;
      timeout_r <= TIMEOUT_RST;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cfg_wr_en) timeout_r <= cfg_wr_data;
      if (cmd.load) begin
        op_r <= in_tuser;
        idx_r <= in_tdata[3:0];
        type_r <= in_tdata[5:4];
        query_r <= in_tdata[13:6];
        now_r <= in_tdata[45:14];
        fo_r <= in_tdata[46];
        rdy_r <= in_tdata[47];
      end
      if (cmd.cnt_clr) cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + 4'd1;
      if (cmd.adv && adv_need) begin
        last_time_r <= now_r;
        if (any_now) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (act_r[s]) age_r[s] <= sum[s][AGE_W] ? AGE_MAX : sum[s][AGE_W-1:0];
          end
        end
      end
      if (cmd.emit) begin
        if (id_bump) id_r <= id_nxt;
        act_r <= act_after;
        if (do_free) begin
          ack_r[a] <= 1'b0;
          age_r[a] <= '0;
          corr_r[a] <= '0;
        end else if (do_fill) begin
          ack_r[a] <= 1'b0;
          age_r[a] <= '0;
          corr_r[a] <= id_nxt;
        end else if (do_ack) begin
          ack_r[a] <= 1'b1;
          age_r[a] <= '0;
        end
        out_valid_r <= 1'b1;
        out_last_r <= r_last;
        out_user_r <= r_act;
        out_data_r <= {|act_after, r_ans, r_status, r_corr, r_slot};
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
  assign out_tlast = out_last_r;
endmodule

// ===== src/pending_request_tracker_timeout.sv =====
`timescale 1ns / 1ps
// Pending request tracker with timeout: sixteen slots, each holding one request
// with a correlation ID and a saturating age. Ages advance by the time elapsed
// since the last advancing word. One item is handled at a time: a single-slot
// operation passes through the advance, execute and wait states; a sweep walks
// the slots one by one up to the last acting slot, emitting a result word for
// each acting slot and waiting for each to be taken, the walk being set by the
// one shared slot read port in the datapath. Result words are held in an output
// register until taken; the next item is accepted after the last result word
// of the current one leaves.
module pending_request_tracker_timeout (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] slot_index, [5:4] click_type, [13:6] query_correlation_id,
  // [45:14] now_ms, [46] failover, [47] transport_ready
  input  logic [47:0] in_tdata,
  // [2:0] req_type
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] out_slot, [11:4] out_correlation_id, [13:12] request_status,
  // [14] answer, [15] any_active
  output logic [15:0] out_tdata,
  // [2:0] action
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import prt_pkg::*;

  prt_cmd_t  cmd;
  prt_stat_t stat;

  prt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  prt_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast), .cmd(cmd), .stat(stat)
  );

`include "pending_request_tracker_timeout_assert.svh"

  `PRT_ASSERT_NOW(a_idle_no_out, clk, rst_n, in_tready, !out_tvalid)
  `PRT_ASSERT_NEXT(a_last_frees, clk, rst_n, out_tvalid && out_tready && out_tlast, in_tready)
  `PRT_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready && !out_tvalid)
endmodule
